// ===== rtl/itm_trace_packet_deframer_defines.svh =====
// Assertion macros for the ITM trace packet deframer.
// Used by itm_trace_packet_deframer.sv; the including module supplies clock and reset.
`ifndef ITM_TRACE_PACKET_DEFRAMER_DEFINES_SVH
`define ITM_TRACE_PACKET_DEFRAMER_DEFINES_SVH

// check cons in the same cycle as ante
`define ITMDF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define ITMDF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/itmdf_pkg.sv =====
// Types and constants of the ITM trace packet deframer.
// No dependencies; imported by itm_trace_packet_deframer.
package itmdf_pkg;

   localparam int unsigned PKT_MAX = 5;

   localparam logic [7:0] OVERFLOW_MARK = 8'h70;
   localparam logic [7:0] SYNC_HEADER   = 8'h00;

   localparam logic [1:0] STATUS_PACKET   = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   localparam logic [1:0] SIZE_CODE_WORD = 2'd3;

   typedef logic [7:0] trace_byte_type;

   typedef struct packed {
      logic [1:0]                     status;
      logic [2:0]                     length;
      trace_byte_type [PKT_MAX-1:0]   bytes;
   } result_type;

endpackage

// ===== rtl/itm_trace_packet_deframer.sv =====
// ITM/SWO trace packet deframer: one trace byte per request, framed packets out.
// Depends on itmdf_pkg and itm_trace_packet_deframer_defines.svh.
//
// Usage:
//   The request channel (req_valid, req_stall, req_byte_in) takes one raw trace
//   byte per accepted request. The response channel (rsp_valid, rsp_stall,
//   rsp_status, rsp_length, rsp_byte0..rsp_byte4) gives a response for a byte
//   that completes a packet, is an overflow marker or overruns five bytes.
//   Bytes beyond rsp_length, and all bytes of a status response, read as zero.
//   A response enters the response register, or the skid stage while rsp_stall holds one.
//   Throughput: one byte per cycle while req_stall is low; the header decode and
//   packet assembly sit between the parser state registers and the response register.
//   A response register with a one-entry skid stage behind it lets requests
//   keep flowing while a response waits; req_stall rises only when the skid
//   stage is also occupied, and falls once the receiver takes a response.
//   Reset clears the parser to the header phase and empties both response
//   stages; no clearing pass is needed.
module itm_trace_packet_deframer
   import itmdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_length,
   output logic [7:0] rsp_byte0,
   output logic [7:0] rsp_byte1,
   output logic [7:0] rsp_byte2,
   output logic [7:0] rsp_byte3,
   output logic [7:0] rsp_byte4
);

`include "itm_trace_packet_deframer_defines.svh"

   logic                          collecting_ff, collecting_in;
   logic [2:0]                    held_ff, held_in;
   logic [2:0]                    target_ff, target_in;
   logic                          eoc_ff, eoc_in;
   trace_byte_type [PKT_MAX-1:0]  buf_ff, buf_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   result_type                    rsp_data_ff, rsp_data_in;
   logic                          skid_valid_ff, skid_valid_in;
   result_type                    skid_data_ff, skid_data_in;

   logic                          accept;
   logic                          out_ready;
   logic                          res_valid;
   result_type                    res;
   logic                          emit_packet;
   logic [1:0]                    size_code;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign out_ready = ~rsp_valid_ff | ~rsp_stall;
   assign size_code = req_byte_in[1:0];

   // parser step
   always_comb begin
      collecting_in = collecting_ff;
      held_in       = held_ff;
      target_in     = target_ff;
      eoc_in        = eoc_ff;
      buf_in        = buf_ff;
      res_valid     = 1'b0;
      emit_packet   = 1'b0;
      res           = '0;
      if (accept) begin
         if (!collecting_ff) begin
            held_in   = 3'd0;
            target_in = 3'd0;
            eoc_in    = 1'b0;
            if (req_byte_in == OVERFLOW_MARK) begin
               res_valid  = 1'b1;
               res.status = STATUS_OVERFLOW;
            end else if (!req_byte_in[2]) begin
               buf_in[0] = req_byte_in;
               held_in   = 3'd1;
               if (req_byte_in == SYNC_HEADER) begin
                  target_in     = 3'(PKT_MAX);
                  collecting_in = 1'b1;
               end else if (req_byte_in[3:0] == 4'h0) begin
                  if (!req_byte_in[7]) begin
                     emit_packet = 1'b1;
                  end else begin
                     eoc_in        = 1'b1;
                     collecting_in = 1'b1;
                  end
               end else begin
                  target_in     = (size_code == SIZE_CODE_WORD) ? 3'd5 : {1'b0, size_code} + 3'd1;
                  collecting_in = 1'b1;
               end
            end
         end else if (held_ff >= 3'(PKT_MAX)) begin
            collecting_in = 1'b0;
            res_valid     = 1'b1;
            res.status    = STATUS_TOO_LONG;
         end else begin
            for (int k = 0; k < PKT_MAX; k++) begin
               if (held_ff == 3'(k)) begin
                  buf_in[k] = req_byte_in;
               end
            end
            held_in = held_ff + 3'd1;
            if ((eoc_ff && !req_byte_in[7]) || held_in == target_ff) begin
               collecting_in = 1'b0;
               emit_packet   = 1'b1;
            end
         end
      end
      if (emit_packet) begin
         res_valid  = 1'b1;
         res.status = STATUS_PACKET;
         res.length = held_in;
         for (int k = 0; k < PKT_MAX; k++) begin
            res.bytes[k] = (3'(k) < held_in) ? buf_in[k] : 8'h00;
         end
      end
   end

   // response register and skid stage
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_ready) begin
         rsp_valid_in  = skid_valid_ff | res_valid;
         rsp_data_in   = skid_valid_ff ? skid_data_ff : res;
         skid_valid_in = 1'b0;
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         held_ff       <= 3'd0;
         target_ff     <= 3'd0;
         eoc_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         collecting_ff <= collecting_in;
         held_ff       <= held_in;
         target_ff     <= target_in;
         eoc_ff        <= eoc_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff       <= buf_in;
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_data_ff.status;
   assign rsp_length = rsp_data_ff.length;
   assign rsp_byte0  = rsp_data_ff.bytes[0];
   assign rsp_byte1  = rsp_data_ff.bytes[1];
   assign rsp_byte2  = rsp_data_ff.bytes[2];
   assign rsp_byte3  = rsp_data_ff.bytes[3];
   assign rsp_byte4  = rsp_data_ff.bytes[4];

   `ITMDF_ASSERT_NOW(a_skid_behind_rsp, skid_valid_ff, rsp_valid_ff, "skid full with response empty")
   `ITMDF_ASSERT_NOW(a_held_range, collecting_ff, (held_ff >= 3'd1) && (held_ff <= 3'(PKT_MAX)), "held count out of range while collecting")
   `ITMDF_ASSERT_NOW(a_length_status, rsp_valid_ff, (rsp_data_ff.status == STATUS_PACKET) == (rsp_data_ff.length != 3'd0), "length disagrees with status")
   `ITMDF_ASSERT_NEXT(a_skid_holds, skid_valid_ff && rsp_stall, skid_valid_ff && $stable(skid_data_ff), "skid entry lost under stall")

endmodule

// ===== sim/itm_trace_packet_deframer_tb.sv =====
// Testbench for itm_trace_packet_deframer: directed and random trace byte streams,
// each response checked against a packet framing predictor held in a scoreboard class.
// Depends on itmdf_pkg and the deframer RTL; reads no files.
module itm_trace_packet_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import itmdf_pkg::*;

   class frame_scoreboard;
      bit             collecting;
      trace_byte_type frame [PKT_MAX];
      int unsigned    held;
      int unsigned    want_len;
      bit             ends_on_clear;
      result_type     expected_q [$];
      int unsigned    errors;

      function result_type framed_packet();
         result_type r;
         r        = '0;
         r.status = STATUS_PACKET;
         r.length = held[2:0];
         for (int k = 0; k < PKT_MAX; k++)
            r.bytes[k] = (k < held) ? frame[k] : 8'h00;
         return r;
      endfunction

      function result_type status_only(logic [1:0] st);
         result_type r;
         r        = '0;
         r.status = st;
         return r;
      endfunction

      function void note_request(trace_byte_type b);
         if (!collecting) begin
            held          = 0;
            want_len      = 0;
            ends_on_clear = 0;
            if (b == OVERFLOW_MARK) begin
               expected_q.push_back(status_only(STATUS_OVERFLOW));
               return;
            end
            if (b[2])
               return;
            frame[0] = b;
            held     = 1;
            if (b == SYNC_HEADER) begin
               want_len = PKT_MAX;
            end else if (b[3:0] == 4'h0) begin
               if (!b[7]) begin
                  expected_q.push_back(framed_packet());
                  return;
               end
               ends_on_clear = 1;
            end else begin
               want_len = (b[1:0] == SIZE_CODE_WORD) ? PKT_MAX : b[1:0] + 1;
            end
            collecting = 1;
            return;
         end
         if (held >= PKT_MAX) begin
            collecting = 0;
            expected_q.push_back(status_only(STATUS_TOO_LONG));
            return;
         end
         frame[held] = b;
         held++;
         if ((ends_on_clear && !b[7]) || held == want_len) begin
            collecting = 0;
            expected_q.push_back(framed_packet());
         end
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected response: status %0d length %0d", got.status, got.length);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, got.length);
            errors++;
         end
         for (int k = 0; k < PKT_MAX; k++)
            if (got.bytes[k] !== want.bytes[k]) begin
               $error("byte%0d: expected 0x%02h, got 0x%02h", k, want.bytes[k], got.bytes[k]);
               errors++;
            end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   localparam int unsigned CYCLE_LIMIT = 200000;

   logic           clock       = 1'b0;
   logic           reset       = 1'b1;
   logic           req_valid   = 1'b0;
   logic           req_stall;
   logic [7:0]     req_byte_in = 8'h00;
   logic           rsp_valid;
   logic           rsp_stall   = 1'b0;
   logic [1:0]     rsp_status;
   logic [2:0]     rsp_length;
   logic [7:0]     rsp_byte0, rsp_byte1, rsp_byte2, rsp_byte3, rsp_byte4;

   int unsigned     sender_idle_pct   = 7;
   int unsigned     receiver_idle_pct = 72;
   int unsigned     requests_sent     = 0;
   int unsigned     cycles            = 0;
   frame_scoreboard sb                = new();
   result_type      seen;

   trace_byte_type opening_stream [$] = '{
      8'h70, 8'hFF,
      8'h00, 8'hAA, 8'h55, 8'hFF, 8'h70,
      8'h10,
      8'h80, 8'h85, 8'h00,
      8'hF0, 8'h80, 8'hFF, 8'h81, 8'hC0, 8'h7F,
      8'h01, 8'h7F,
      8'h03, 8'h00, 8'hFF, 8'h80, 8'h01
   };

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   itm_trace_packet_deframer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_byte_in (req_byte_in),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_length  (rsp_length),
      .rsp_byte0   (rsp_byte0),
      .rsp_byte1   (rsp_byte1),
      .rsp_byte2   (rsp_byte2),
      .rsp_byte3   (rsp_byte3),
      .rsp_byte4   (rsp_byte4)
   );

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < receiver_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_byte_in);
         if (rsp_valid && !rsp_stall) begin
            seen.status   = rsp_status;
            seen.length   = rsp_length;
            seen.bytes[0] = rsp_byte0;
            seen.bytes[1] = rsp_byte1;
            seen.bytes[2] = rsp_byte2;
            seen.bytes[3] = rsp_byte3;
            seen.bytes[4] = rsp_byte4;
            sb.check_response(seen);
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   task automatic send_request(input trace_byte_type b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      requests_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random_sequence();
      trace_byte_type hdr;
      trace_byte_type b;
      int unsigned    kind;
      int unsigned    count;
      kind = $urandom_range(99);
      if (kind < 5) begin
         send_request(OVERFLOW_MARK);
      end else if (kind < 10) begin
         hdr    = 8'($urandom_range(255));
         hdr[2] = 1'b1;
         send_request(hdr);
      end else if (kind < 18) begin
         send_request(8'($urandom_range(255)));
      end else if (kind < 30) begin
         send_request(SYNC_HEADER);
         repeat (PKT_MAX - 1) send_request(8'($urandom_range(255)));
      end else if (kind < 40) begin
         hdr      = 8'h00;
         hdr[6:4] = 3'($urandom_range(1, 6));
         send_request(hdr);
      end else if (kind < 60) begin
         hdr      = 8'h80;
         hdr[6:4] = 3'($urandom_range(7));
         send_request(hdr);
         count = $urandom_range(5);
         repeat (count) begin
            b    = 8'($urandom_range(255));
            b[7] = 1'b1;
            send_request(b);
         end
         b    = 8'($urandom_range(255));
         b[7] = 1'b0;
         send_request(b);
      end else begin
         do begin
            hdr    = 8'($urandom_range(255));
            hdr[2] = 1'b0;
         end while (hdr[3:0] == 4'h0);
         case (hdr[1:0])
            SIZE_CODE_WORD: count = 4;
            2'd0:           count = PKT_MAX;
            default:        count = 32'(hdr[1:0]);
         endcase
         send_request(hdr);
         repeat (count) send_request(8'($urandom_range(255)));
      end
   endtask

   initial begin
      int unsigned quota;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_stream[i])
         send_request(opening_stream[i]);
      drain();
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct   = (phase == 0) ? 7 : (phase == 1) ? 72 : 0;
         receiver_idle_pct <= (phase == 0) ? 72 : (phase == 1) ? 7 : 0;
         quota             = 600 + 550 * phase;
         while (requests_sent < quota)
            send_random_sequence();
         drain();
      end
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
